// ===== src/dfs_pkg.sv =====
// Shared types, constants and a helper function of the depth foveated subsampler.
package dfs_pkg;

   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int POS_W   = 24;
   localparam int SLOT_W  = 20;
   localparam int DEPTH_W = 16;
   localparam int CFG_W   = 11;
   localparam int IDX_W   = 1;
   localparam int DIV_W   = 18;
   localparam int SUM_W   = 20;
   localparam int CNT_W   = 4;

   localparam logic [DIV_W-1:0] REQ_BASE_SQ = 18'd250500;
   localparam logic [DIM_W-1:0] MIN_DIM     = 13'd3;

   localparam logic [IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [IDX_W-1:0] CSR_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam int DIV3_SHIFT = DIM_W + 1;
   localparam int DIV3_MUL   = (2 ** DIV3_SHIFT + 2) / 3;

   typedef struct packed {
      logic               op;
      logic [DEPTH_W-1:0] depth;
   } req_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] value;
      logic [SLOT_W-1:0]  slot;
      logic               last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic              central;
      logic              top;
      logic              bottom;
      logic              left;
      logic              right;
      logic              last;
      logic [SLOT_W-1:0] slot;
   } task_type;

   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [DIM_W-1:0] cs;
      logic [DIM_W-1:0] ce;
      logic [DIM_W-1:0] rs;
      logic [DIM_W-1:0] re;
      logic [DIM_W-1:0] last_row;
      logic [DIM_W-1:0] last_col;
   } geo_type;

   // Exact division by three through a reciprocal multiply.
   function automatic logic [DIM_W-1:0] div3(input logic [DIM_W-1:0] x);
      logic [2*DIM_W-1:0] prod;
      prod = (2*DIM_W)'(x) * (2*DIM_W)'(DIV3_MUL);
      return DIM_W'(prod >> DIV3_SHIFT);
   endfunction

endpackage

// ===== src/dfs_fifo.sv =====
// Small first-in first-out queue of packed words.
module dfs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/dfs_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dfs_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [dfs_pkg::DIV_W-1:0] dividend,
   input  logic [dfs_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [dfs_pkg::DIV_W-1:0] quotient
);
   import dfs_pkg::*;

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIV_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    shifted;

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign shifted  = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = STEP_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = shifted - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ===== src/dfs_front.sv =====
// Front end: configuration, frame geometry, arrival tracking and decision scheduling.
module dfs_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int ADDR_W     = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [dfs_pkg::IDX_W-1:0]   csr_index,
   input  logic [dfs_pkg::CFG_W-1:0]   csr_wr_data,
   input  logic                        req_push,
   output logic                        req_full,
   input  dfs_pkg::req_type            req_data,
   output logic                        task_push,
   input  logic                        task_full,
   input  logic                        task_empty,
   output dfs_pkg::task_type           task_data,
   input  logic                        back_idle,
   output logic                        store_wr_en,
   output logic [ADDR_W-1:0]           store_wr_addr,
   output logic [dfs_pkg::DEPTH_W-1:0] store_wr_data,
   output logic [dfs_pkg::DIM_W-1:0]   frame_w
);
   import dfs_pkg::*;

   localparam logic [1:0] F_IDLE  = 2'd0;
   localparam logic [1:0] F_PROC  = 2'd1;
   localparam logic [1:0] F_DRAIN = 2'd2;
   localparam logic [2:0] SETTLE_CYCLES = 3'd4;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] x;
      x = DIM_W'(v);
      if (x < MIN_DIM) begin
         return MIN_DIM;
      end
      if (x > hi) begin
         return hi;
      end
      return x;
   endfunction

   logic [CFG_W-1:0]   cfg_w_ff, cfg_w_in, cfg_h_ff, cfg_h_in;
   logic [2:0]         settle_ff, settle_in;
   logic [1:0]         state_ff, state_in;
   logic               op_ff, op_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [POS_W-1:0]   apos_ff, apos_in, dpos_ff, dpos_in;
   logic [COORD_W-1:0] acol_ff, acol_in, arow_ff, arow_in;
   logic [COORD_W-1:0] dcol_ff, dcol_in, drow_ff, drow_in;
   logic [1:0]         dcm_ff, dcm_in, drm_ff, drm_in;
   logic               arr_done_ff, arr_done_in;
   logic [DIM_W-1:0]   gap_ff, gap_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   // Geometry pipeline, three register stages after the configuration registers.
   logic [DIM_W-1:0] g1_w_ff, g1_h_ff, g1_wq_ff, g1_hq_ff, g1_cbq_ff, g1_rbq_ff;
   logic [DIM_W-1:0] g2_w_ff, g2_h_ff, g2_wq_ff, g2_ce_ff, g2_hq_ff, g2_re_ff;
   logic [DIM_W-1:0] g2_cb_ff, g2_lr_ff;
   geo_type          geo_ff, geo_in;
   logic [DIM_W-1:0] eff_w, eff_h, rb_full, re_m1, lr_mod, lc;

   assign eff_w   = clamp_dim(cfg_w_ff, DIM_W'(MAX_WIDTH));
   assign eff_h   = clamp_dim(cfg_h_ff, DIM_W'(MAX_HEIGHT));
   assign rb_full = (g1_rbq_ff << 1) + g1_rbq_ff + DIM_W'(1);
   assign re_m1   = (g1_hq_ff << 1) - DIM_W'(1);
   assign lr_mod  = g2_lr_ff - ((div3(g2_lr_ff) << 1) + div3(g2_lr_ff));

   always_comb begin
      lc = (lr_mod == DIM_W'(1)) ? g2_cb_ff : '0;
      if (g2_lr_ff >= g2_hq_ff && g2_lr_ff < g2_re_ff && g2_ce_ff > lc) begin
         lc = g2_ce_ff;
      end
      geo_in.w        = g2_w_ff;
      geo_in.h        = g2_h_ff;
      geo_in.cs       = g2_wq_ff;
      geo_in.ce       = g2_ce_ff;
      geo_in.rs       = g2_hq_ff;
      geo_in.re       = g2_re_ff;
      geo_in.last_row = g2_lr_ff;
      geo_in.last_col = lc;
   end

   always_ff @(posedge clock) begin
      g1_w_ff   <= eff_w;
      g1_h_ff   <= eff_h;
      g1_wq_ff  <= div3(eff_w);
      g1_hq_ff  <= div3(eff_h);
      g1_cbq_ff <= div3(eff_w - DIM_W'(2));
      g1_rbq_ff <= div3(eff_h - DIM_W'(2));
      g2_w_ff   <= g1_w_ff;
      g2_h_ff   <= g1_h_ff;
      g2_wq_ff  <= g1_wq_ff;
      g2_ce_ff  <= g1_wq_ff << 1;
      g2_hq_ff  <= g1_hq_ff;
      g2_re_ff  <= g1_hq_ff << 1;
      g2_cb_ff  <= (g1_cbq_ff << 1) + g1_cbq_ff + DIM_W'(1);
      g2_lr_ff  <= (rb_full > re_m1) ? rb_full : re_m1;
      geo_ff    <= geo_in;
   end

   assign frame_w  = geo_ff.w;
   assign req_full = (state_ff != F_IDLE) || (settle_ff != '0);

   logic             is_px, skip_all, wr, decide, central, block, kept, final_pos;
   logic             arr_done_nx;
   logic [DIM_W-1:0] gap_nx;

   always_comb begin
      is_px       = (op_ff == OP_PIXEL);
      skip_all    = (is_px && arr_done_ff) ||
                    (!is_px && apos_ff == '0 && !arr_done_ff);
      wr          = !skip_all && !arr_done_ff;
      arr_done_nx = arr_done_ff || (wr && {1'b0, acol_ff} == geo_ff.w - DIM_W'(1) &&
                                    {1'b0, arow_ff} == geo_ff.h - DIM_W'(1));
      gap_nx      = gap_ff + DIM_W'(wr);
      decide      = !skip_all && (arr_done_nx || gap_nx >= geo_ff.w + DIM_W'(2));
      central     = {1'b0, drow_ff} >= geo_ff.rs && {1'b0, drow_ff} < geo_ff.re &&
                    {1'b0, dcol_ff} >= geo_ff.cs && {1'b0, dcol_ff} <= geo_ff.ce;
      block       = (drm_ff == 2'd1) && (dcm_ff == 2'd1);
      kept        = central || block;
      final_pos   = {1'b0, dcol_ff} == geo_ff.w - DIM_W'(1) &&
                    {1'b0, drow_ff} == geo_ff.h - DIM_W'(1);

      task_data.pos     = dpos_ff;
      task_data.central = central;
      task_data.top     = (drow_ff == '0);
      task_data.bottom  = ({1'b0, drow_ff} == geo_ff.h - DIM_W'(1));
      task_data.left    = (dcol_ff == '0);
      task_data.right   = ({1'b0, dcol_ff} == geo_ff.w - DIM_W'(1));
      task_data.last    = {1'b0, drow_ff} == geo_ff.last_row &&
                          {1'b0, dcol_ff} == geo_ff.last_col;
      task_data.slot    = slot_ff;

      store_wr_addr = apos_ff[ADDR_W-1:0];
      store_wr_data = is_px ? depth_ff : '0;
      store_wr_en   = 1'b0;
      task_push     = 1'b0;

      cfg_w_in    = cfg_w_ff;
      cfg_h_in    = cfg_h_ff;
      settle_in   = (settle_ff != '0) ? settle_ff - 1'b1 : settle_ff;
      state_in    = state_ff;
      op_in       = op_ff;
      depth_in    = depth_ff;
      apos_in     = apos_ff;
      acol_in     = acol_ff;
      arow_in     = arow_ff;
      arr_done_in = arr_done_ff;
      gap_in      = gap_ff;
      dpos_in     = dpos_ff;
      dcol_in     = dcol_ff;
      drow_in     = drow_ff;
      dcm_in      = dcm_ff;
      drm_in      = drm_ff;
      slot_in     = slot_ff;

      if (csr_wr_en) begin
         if (csr_index == CSR_WIDTH) begin
            cfg_w_in = csr_wr_data;
         end else begin
            cfg_h_in = csr_wr_data;
         end
         settle_in   = SETTLE_CYCLES;
         apos_in     = '0;
         acol_in     = '0;
         arow_in     = '0;
         arr_done_in = 1'b0;
         gap_in      = '0;
         dpos_in     = '0;
         dcol_in     = '0;
         drow_in     = '0;
         dcm_in      = '0;
         drm_in      = '0;
         slot_in     = '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_push && !req_full) begin
                  op_in    = req_data.op;
                  depth_in = req_data.depth;
                  state_in = F_PROC;
               end
            end
            F_PROC: begin
               if (!task_full) begin
                  state_in = F_IDLE;
                  if (wr) begin
                     store_wr_en = 1'b1;
                     apos_in     = apos_ff + 1'b1;
                     if ({1'b0, acol_ff} == geo_ff.w - DIM_W'(1)) begin
                        acol_in = '0;
                        arow_in = arow_ff + 1'b1;
                     end else begin
                        acol_in = acol_ff + 1'b1;
                     end
                  end
                  arr_done_in = arr_done_nx;
                  gap_in      = gap_nx;
                  if (decide) begin
                     task_push = kept;
                     if (kept) begin
                        slot_in = slot_ff + 1'b1;
                     end
                     gap_in  = gap_nx - DIM_W'(1);
                     dpos_in = dpos_ff + 1'b1;
                     if ({1'b0, dcol_ff} == geo_ff.w - DIM_W'(1)) begin
                        dcol_in = '0;
                        dcm_in  = '0;
                        drow_in = drow_ff + 1'b1;
                        drm_in  = (drm_ff == 2'd2) ? 2'd0 : drm_ff + 1'b1;
                     end else begin
                        dcol_in = dcol_ff + 1'b1;
                        dcm_in  = (dcm_ff == 2'd2) ? 2'd0 : dcm_ff + 1'b1;
                     end
                     if (final_pos) begin
                        state_in    = F_DRAIN;
                        apos_in     = '0;
                        acol_in     = '0;
                        arow_in     = '0;
                        arr_done_in = 1'b0;
                        gap_in      = '0;
                        dpos_in     = '0;
                        dcol_in     = '0;
                        drow_in     = '0;
                        dcm_in      = '0;
                        drm_in      = '0;
                        slot_in     = '0;
                     end
                  end
               end
            end
            F_DRAIN: begin
               if (task_empty && back_idle && !task_push) begin
                  state_in = F_IDLE;
               end
            end
            default: begin
               state_in = F_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff    <= WIDTH_RESET;
         cfg_h_ff    <= HEIGHT_RESET;
         settle_ff   <= SETTLE_CYCLES;
         state_ff    <= F_IDLE;
         apos_ff     <= '0;
         acol_ff     <= '0;
         arow_ff     <= '0;
         arr_done_ff <= 1'b0;
         gap_ff      <= '0;
         dpos_ff     <= '0;
         dcol_ff     <= '0;
         drow_ff     <= '0;
         dcm_ff      <= '0;
         drm_ff      <= '0;
         slot_ff     <= '0;
      end else begin
         cfg_w_ff    <= cfg_w_in;
         cfg_h_ff    <= cfg_h_in;
         settle_ff   <= settle_in;
         state_ff    <= state_in;
         apos_ff     <= apos_in;
         acol_ff     <= acol_in;
         arow_ff     <= arow_in;
         arr_done_ff <= arr_done_in;
         gap_ff      <= gap_in;
         dpos_ff     <= dpos_in;
         dcol_ff     <= dcol_in;
         drow_ff     <= drow_in;
         dcm_ff      <= dcm_in;
         drm_ff      <= drm_in;
         slot_ff     <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      depth_ff <= depth_in;
   end

endmodule

// ===== src/dfs_back.sv =====
// Back end: sample store, neighbourhood gathering, nearest-to-mean pick and requantisation.
module dfs_back #(
   parameter int ADDR_W = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        store_wr_en,
   input  logic [ADDR_W-1:0]           store_wr_addr,
   input  logic [dfs_pkg::DEPTH_W-1:0] store_wr_data,
   input  logic [dfs_pkg::DIM_W-1:0]   frame_w,
   input  logic                        task_empty,
   input  dfs_pkg::task_type           task_data,
   output logic                        task_pop,
   input  logic                        out_full,
   output logic                        out_push,
   output dfs_pkg::rsp_type            out_data,
   output logic                        idle
);
   import dfs_pkg::*;

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_CEN    = 3'd1;
   localparam logic [2:0] B_GATHER = 3'd2;
   localparam logic [2:0] B_PICK   = 3'd3;
   localparam logic [2:0] B_DIV1   = 3'd4;
   localparam logic [2:0] B_DIV2   = 3'd5;
   localparam logic [2:0] B_OUT    = 3'd6;
   localparam logic [CNT_W-1:0] LAST_K = 4'd9;
   localparam logic [CNT_W-1:0] MID_K  = 4'd4;

   logic [DEPTH_W-1:0] store_ff [2**ADDR_W];
   logic [DEPTH_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;

   logic [2:0]         state_ff, state_in;
   task_type           task_ff, task_in;
   logic [DEPTH_W-1:0] win_ff [9];
   logic [8:0]         vld_ff, vld_in;
   logic [SUM_W-1:0]   sum_ff, sum_in, bestdiff_ff, bestdiff_in;
   logic [CNT_W-1:0]   n_ff, n_in, k_ff, k_in, cap_k;
   logic [ADDR_W-1:0]  rowaddr_ff, rowaddr_in;
   logic [1:0]         dc_ff, dc_in, dr_ff, dr_in;
   logic [DEPTH_W-1:0] best_ff, best_in, value_ff, value_in;
   logic               have_ff, have_in;
   logic               win_we, issue_valid;
   logic [DEPTH_W-1:0] win_wdata;
   logic [SUM_W-1:0]   scaled, diff;
   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_divisor, div_quotient;

   dfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (REQ_BASE_SQ),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign idle     = (state_ff == B_IDLE);
   assign task_pop = (state_ff == B_IDLE) && !task_empty;
   assign cap_k    = k_ff - 1'b1;

   assign out_data.value         = value_ff;
   assign out_data.slot          = task_ff.slot;
   assign out_data.last_of_frame = task_ff.last;

   always_ff @(posedge clock) begin
      if (store_wr_en) begin
         store_ff[store_wr_addr] <= store_wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   always_comb begin
      scaled = SUM_W'(n_ff) * SUM_W'(win_ff[k_ff]);
      diff   = (scaled > sum_ff) ? scaled - sum_ff : sum_ff - scaled;
      issue_valid = !((dr_ff == 2'd0 && task_ff.top) || (dr_ff == 2'd2 && task_ff.bottom) ||
                      (dc_ff == 2'd0 && task_ff.left) || (dc_ff == 2'd2 && task_ff.right));
      rd_addr = (state_ff == B_IDLE) ? task_data.pos[ADDR_W-1:0] : rowaddr_ff + ADDR_W'(dc_ff);

      state_in    = state_ff;
      task_in     = task_ff;
      vld_in      = vld_ff;
      sum_in      = sum_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      rowaddr_in  = rowaddr_ff;
      dc_in       = dc_ff;
      dr_in       = dr_ff;
      best_in     = best_ff;
      bestdiff_in = bestdiff_ff;
      have_in     = have_ff;
      value_in    = value_ff;
      win_we      = 1'b0;
      win_wdata   = '0;
      div_start   = 1'b0;
      div_divisor = {2'b00, best_ff};
      out_push    = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (!task_empty) begin
               task_in    = task_data;
               rowaddr_in = task_data.pos[ADDR_W-1:0] - ADDR_W'(frame_w) - ADDR_W'(1);
               dc_in      = '0;
               dr_in      = '0;
               k_in       = '0;
               sum_in     = '0;
               n_in       = '0;
               have_in    = 1'b0;
               state_in   = task_data.central ? B_CEN : B_GATHER;
            end
         end
         B_CEN: begin
            value_in = rd_data_ff;
            state_in = B_OUT;
         end
         B_GATHER: begin
            // Reads issue in the cycle before the capture of the same neighbour.
            if (k_ff != LAST_K) begin
               vld_in[k_ff] = issue_valid;
               if (dc_ff == 2'd2) begin
                  dc_in      = '0;
                  dr_in      = dr_ff + 1'b1;
                  rowaddr_in = rowaddr_ff + ADDR_W'(frame_w);
               end else begin
                  dc_in = dc_ff + 1'b1;
               end
            end
            if (k_ff != '0) begin
               win_we = 1'b1;
               if (vld_ff[cap_k]) begin
                  win_wdata = rd_data_ff;
                  sum_in    = sum_ff + SUM_W'(rd_data_ff);
                  n_in      = n_ff + 1'b1;
               end
            end
            if (k_ff == LAST_K) begin
               k_in     = '0;
               state_in = B_PICK;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         B_PICK: begin
            if (k_ff != LAST_K) begin
               if (vld_ff[k_ff] && (!have_ff || diff < bestdiff_ff)) begin
                  have_in     = 1'b1;
                  bestdiff_in = diff;
                  best_in     = win_ff[k_ff];
               end
               k_in = k_ff + 1'b1;
            end else if (win_ff[MID_K] == '0 || best_ff == '0) begin
               value_in = '0;
               state_in = B_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = B_DIV1;
            end
         end
         B_DIV1: begin
            if (div_done) begin
               div_start   = 1'b1;
               div_divisor = div_quotient;
               state_in    = B_DIV2;
            end
         end
         B_DIV2: begin
            if (div_done) begin
               value_in = div_quotient[DEPTH_W-1:0];
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff     <= task_in;
      vld_ff      <= vld_in;
      sum_ff      <= sum_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      rowaddr_ff  <= rowaddr_in;
      dc_ff       <= dc_in;
      dr_ff       <= dr_in;
      best_ff     <= best_in;
      bestdiff_ff <= bestdiff_in;
      have_ff     <= have_in;
      value_ff    <= value_in;
      if (win_we) begin
         win_ff[cap_k] <= win_wdata;
      end
   end

endmodule

// ===== src/depth_foveated_subsampler_core.sv =====
// Top level of the depth foveated subsampler: front end, task queue, back end, result queue.
//
// Depth pixels of a frame enter in raster order through req_push/req_full; a flush
// transfer (op set) stands for a zero pixel and drains the last rows of the frame.
// Pixels in the central third pass unchanged; elsewhere only 3x3 block centres are
// kept and replaced by the neighbour nearest the block mean, requantised through
// two 18-bit divisions. Kept values leave through rsp_empty/rsp_pop with their
// buffer slot and a flag on the frame's final value.
// The front end takes a new transfer only once it has handled the last one. A position
// is decided once the pixel below and right of it has arrived, so decisions trail their
// pixels by one row plus one. In the back end a central pixel needs one store read; a
// block centre needs nine store reads, nine compares and the two one-bit-per-cycle
// divisions; a two-entry task queue lets the front end run on while the back end works.
// At the end of a frame the front end holds req_full until the back end has drained.
// Reset, and any csr write, clears the frame position; req_full then stays high
// while the frame geometry settles. The sample store is not cleared.
// When the receiver stalls, results wait in a two-entry queue and then back up.
module depth_foveated_subsampler_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [dfs_pkg::IDX_W-1:0] csr_index,
   input  logic [dfs_pkg::CFG_W-1:0] csr_wr_data,
   input  logic                      req_push,
   output logic                      req_full,
   input  dfs_pkg::req_type          req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output dfs_pkg::rsp_type          rsp_data
);
   import dfs_pkg::*;

   // A queued block centre can wait while the front end runs on to later kept
   // positions, so the store spans at least four rows plus eight samples.
   localparam int ADDR_W = $clog2(4 * MAX_WIDTH + 8);
   localparam int TASK_W = $bits(task_type);
   localparam int RSP_W  = $bits(rsp_type);

   logic               task_push, task_full, task_empty, task_pop, back_idle;
   task_type           task_wdata, task_rdata;
   logic [TASK_W-1:0]  task_rbits;
   logic               store_wr_en;
   logic [ADDR_W-1:0]  store_wr_addr;
   logic [DEPTH_W-1:0] store_wr_data;
   logic [DIM_W-1:0]   frame_w;
   logic               out_push, out_full;
   rsp_type            out_data;
   logic [RSP_W-1:0]   rsp_bits;

   dfs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .task_push     (task_push),
      .task_full     (task_full),
      .task_empty    (task_empty),
      .task_data     (task_wdata),
      .back_idle     (back_idle),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .frame_w       (frame_w)
   );

   dfs_fifo #(
      .WIDTH (TASK_W),
      .DEPTH (2)
   ) u_task_q (
      .clock     (clock),
      .reset     (reset),
      .push      (task_push),
      .push_data (task_wdata),
      .full      (task_full),
      .pop       (task_pop),
      .empty     (task_empty),
      .pop_data  (task_rbits)
   );

   assign task_rdata = task_type'(task_rbits);

   dfs_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .frame_w       (frame_w),
      .task_empty    (task_empty),
      .task_data     (task_rdata),
      .task_pop      (task_pop),
      .out_full      (out_full),
      .out_push      (out_push),
      .out_data      (out_data),
      .idle          (back_idle)
   );

   // Result queue: a finished value waits here while the receiver stalls.
   dfs_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_bits)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule
